// ===== hdl/dclp_pkg.sv =====
// Shared types, constants and keyword tables of the debug command line parser.
package dclp_pkg;

    localparam int WORD_COUNT = 7;
    localparam int WORD_BITS  = 72;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] KEYWORD_MAX = 4'd15;

    // Command words, right aligned: the first character is the most significant one used.
    localparam logic [WORD_BITS-1:0] WORD_TEXT [WORD_COUNT] = '{
        WORD_BITS'("START"), WORD_BITS'("STOP"), WORD_BITS'("RESET"),
        WORD_BITS'("SETSPEED"), WORD_BITS'("GETSTATUS"),
        WORD_BITS'("SETPARAM"), WORD_BITS'("GETPARAM")
    };
    localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
        4'd5, 4'd4, 4'd5, 4'd8, 4'd9, 4'd8, 4'd8
    };

    typedef enum logic [1:0] {
        STATUS_VALID    = 2'd0,
        STATUS_UNKNOWN  = 2'd1,
        STATUS_BAD_ARGS = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_RESET     = 3'd2,
        CMD_SETSPEED  = 3'd3,
        CMD_GETSTATUS = 3'd4,
        CMD_SETPARAM  = 3'd5,
        CMD_GETPARAM  = 3'd6
    } command_t;

    typedef enum logic [1:0] {
        TOK_DATA     = 2'd0,
        TOK_END      = 2'd1,
        TOK_OVERFLOW = 2'd2
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic        skip;
        logic [7:0]  data;
    } token_t;

    typedef struct packed {
        status_t     status;
        command_t    command;
        logic [31:0] param_left;
        logic [31:0] param_right;
        logic [7:0]  line_checksum;
        logic [31:0] commands_seen;
        logic [31:0] errors_seen;
    } result_t;

    // True when character pos of command word idx exists and equals b.
    function automatic logic word_char_match(input int idx, input logic [3:0] pos,
                                             input logic [7:0] b);
        logic [WORD_BITS-1:0] text;
        int                   len;
        logic                 hit;
        text = WORD_TEXT[idx];
        len  = int'(WORD_LEN[idx]);
        hit  = 1'b0;
        if (int'(pos) < len) begin
            hit = (text[(len - 1 - int'(pos)) * 8 +: 8] == b);
        end
        return hit;
    endfunction

endpackage

// ===== hdl/dclp_fifo.sv =====
// Small register queue used between the parser stages and at the result side.
module dclp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // A request must never be dropped by a producer ignoring full.
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("queue written while full");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hdl/dclp_front.sv =====
// Front end: framing of received bytes into line tokens and the prefix register.
module dclp_front #(
    parameter int LINE_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_data,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      rx_byte,
    output logic            tok_wr,
    output dclp_pkg::token_t tok_data,
    input  logic            tok_full
);
    import dclp_pkg::*;

    localparam int CNT_W = $clog2(LINE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LINE = 2'b10
    } front_state_t;

    front_state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       prefix_reg;
    logic             accept;
    logic             is_term;

    assign cfg_ready = 1'b1;
    assign full      = tok_full;
    assign accept    = push && !tok_full;
    assign is_term   = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        tok_wr         = 1'b0;
        tok_data.kind  = TOK_DATA;
        tok_data.skip  = (count_reg == '0) && (rx_byte == prefix_reg);
        tok_data.data  = rx_byte;
        if (accept)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rx_byte == prefix_reg)
                    begin
                        state_next = ST_LINE;
                        count_next = '0;
                    end
                end
                ST_LINE:
                begin
                    priority if (is_term)
                    begin
                        // An empty line closes silently.
                        state_next    = ST_IDLE;
                        tok_wr        = (count_reg != '0);
                        tok_data.kind = TOK_END;
                    end
                    else if (count_reg == CNT_W'(LINE_DEPTH - 1))
                    begin
                        state_next    = ST_IDLE;
                        tok_wr        = 1'b1;
                        tok_data.kind = TOK_OVERFLOW;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        tok_wr     = 1'b1;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            prefix_reg <= 8'd35;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                prefix_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== hdl/dclp_back.sv =====
// Back end: keyword matching, value parsing, checksum and running counts.
module dclp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_empty,
    input  dclp_pkg::token_t  tok_data,
    output logic              tok_rd,
    output logic              res_wr,
    output dclp_pkg::result_t res_data,
    input  logic              res_full
);
    import dclp_pkg::*;

    typedef enum logic [3:0] {
        PH_KEYWORD = 4'b0001,
        PH_FIRST   = 4'b0010,
        PH_SECOND  = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [WORD_COUNT-1:0]   cand_reg, cand_next;
    logic [3:0]              kwlen_reg, kwlen_next;
    logic                    colon_reg, colon_next;
    logic [31:0]             first_reg, first_next;
    logic [31:0]             second_reg, second_next;
    logic [7:0]              csum_reg, csum_next;
    logic [31:0]             cmd_total_reg, cmd_total_next;
    logic [31:0]             err_total_reg, err_total_next;

    logic                    take;
    logic [7:0]              b;
    logic                    is_digit;
    logic [31:0]             digit;
    logic                    found;
    command_t                cmd;
    status_t                 st;

    assign take     = !tok_empty && !res_full;
    assign tok_rd   = take;
    assign b        = tok_data.data;
    assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign digit    = {28'd0, b[3:0]};

    // Line end decision from the candidate flags and the keyword length.
    always_comb
    begin
        found = 1'b0;
        cmd   = CMD_START;
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            if (cand_reg[i] && (WORD_LEN[i] == kwlen_reg))
            begin
                found = 1'b1;
                cmd   = command_t'(3'(i));
            end
        end
        if (!found)
        begin
            st  = STATUS_UNKNOWN;
            cmd = CMD_START;
        end
        else if (cmd == CMD_SETSPEED)
        begin
            st = (colon_reg && (phase_reg == PH_SECOND || phase_reg == PH_DONE)) ?
                 STATUS_VALID : STATUS_BAD_ARGS;
        end
        else
        begin
            st = STATUS_VALID;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        cand_next      = cand_reg;
        kwlen_next     = kwlen_reg;
        colon_next     = colon_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        csum_next      = csum_reg;
        cmd_total_next = cmd_total_reg;
        err_total_next = err_total_reg;
        res_wr         = 1'b0;
        res_data       = '0;

        if (take)
        begin
            unique case (tok_data.kind)
                TOK_DATA:
                begin
                    csum_next = csum_reg ^ b;
                    if (!tok_data.skip)
                    begin
                        unique case (phase_reg)
                            PH_KEYWORD:
                            begin
                                if (b == CHAR_COLON || b == CHAR_COMMA)
                                begin
                                    colon_next = (b == CHAR_COLON);
                                    phase_next = PH_FIRST;
                                end
                                else
                                begin
                                    for (int i = 0; i < WORD_COUNT; i++)
                                    begin
                                        if (!word_char_match(i, kwlen_reg, b))
                                        begin
                                            cand_next[i] = 1'b0;
                                        end
                                    end
                                    if (kwlen_reg != KEYWORD_MAX)
                                    begin
                                        kwlen_next = kwlen_reg + 1'b1;
                                    end
                                end
                            end
                            PH_FIRST:
                            begin
                                if (b == CHAR_COMMA)
                                begin
                                    phase_next = PH_SECOND;
                                end
                                else if (is_digit)
                                begin
                                    // Times ten as two shifted copies.
                                    first_next = {first_reg[28:0], 3'b000}
                                               + {first_reg[30:0], 1'b0} + digit;
                                end
                            end
                            PH_SECOND:
                            begin
                                if (b == CHAR_COMMA || b == CHAR_NUL)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else if (is_digit)
                                begin
                                    second_next = {second_reg[28:0], 3'b000}
                                                + {second_reg[30:0], 1'b0} + digit;
                                end
                            end
                            PH_DONE:
                            begin
                                phase_next = PH_DONE;
                            end
                            default:
                            begin
                                phase_next = PH_DONE;
                            end
                        endcase
                    end
                end
                TOK_END:
                begin
                    if (st == STATUS_VALID)
                    begin
                        cmd_total_next = cmd_total_reg + 1'b1;
                    end
                    else
                    begin
                        err_total_next = err_total_reg + 1'b1;
                    end
                    res_wr                 = 1'b1;
                    res_data.status        = st;
                    res_data.command       = cmd;
                    if (st == STATUS_VALID && cmd == CMD_SETSPEED)
                    begin
                        res_data.param_left  = first_reg;
                        res_data.param_right = second_reg;
                    end
                    res_data.line_checksum = csum_reg;
                    res_data.commands_seen = cmd_total_next;
                    res_data.errors_seen   = err_total_next;
                end
                TOK_OVERFLOW:
                begin
                    err_total_next         = err_total_reg + 1'b1;
                    res_wr                 = 1'b1;
                    res_data.status        = STATUS_OVERFLOW;
                    res_data.command       = CMD_START;
                    res_data.line_checksum = csum_reg;
                    res_data.commands_seen = cmd_total_reg;
                    res_data.errors_seen   = err_total_next;
                end
                default:
                begin
                    res_wr = 1'b0;
                end
            endcase

            // Every line closes with a cleared parse state for the next one.
            if (tok_data.kind == TOK_END || tok_data.kind == TOK_OVERFLOW)
            begin
                phase_next  = PH_KEYWORD;
                cand_next   = '1;
                kwlen_next  = '0;
                colon_next  = 1'b0;
                first_next  = '0;
                second_next = '0;
                csum_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_KEYWORD;
            cand_reg      <= '1;
            kwlen_reg     <= '0;
            colon_reg     <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            csum_reg      <= '0;
            cmd_total_reg <= '0;
            err_total_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cand_reg      <= cand_next;
            kwlen_reg     <= kwlen_next;
            colon_reg     <= colon_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            csum_reg      <= csum_next;
            cmd_total_reg <= cmd_total_next;
            err_total_reg <= err_total_next;
        end
    end

    // Parsed values leave only with a valid speed command.
    a_params_only_setspeed: assert property (@(posedge clk) disable iff (!rst_n)
        (res_wr && (res_data.param_left != '0 || res_data.param_right != '0))
        |-> (res_data.status == STATUS_VALID && res_data.command == CMD_SETSPEED))
        else $error("parameters reported without a valid speed command");

    // Each result moves exactly one of the two running counts.
    a_one_count_per_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |=> ((cmd_total_reg != $past(cmd_total_reg))
                    ^ (err_total_reg != $past(err_total_reg))))
        else $error("result did not advance exactly one count");

endmodule

// ===== hdl/debug_command_line_parser.sv =====
// Top level of the debug command line parser: front end, token queue, back end, result queue.
// The parser takes one received byte per clock cycle whenever full is low; its rate is set by
// the back end, which handles one byte token per cycle, and by the two-entry token queue that
// lets the front keep accepting while the back waits on a full result queue. A line result is
// written by the back end when it takes the line end token from the token queue, and waits in
// a two-entry result queue until popped; while that queue is full the back end holds and full
// rises once the token queue fills. Bytes seen while no line is open are consumed at full rate
// whenever the token queue has room. The prefix byte is written through the configuration
// channel, which is always ready.
module debug_command_line_parser #(
    parameter int LINE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [2:0]  command,
    output logic [31:0] param_left,
    output logic [31:0] param_right,
    output logic [7:0]  line_checksum,
    output logic [31:0] commands_seen,
    output logic [31:0] errors_seen
);
    import dclp_pkg::*;

    localparam int TOK_W = $bits(token_t);
    localparam int RES_W = $bits(result_t);

    logic    tok_wr, tok_full, tok_rd, tok_empty;
    token_t  tok_in, tok_out;
    logic    res_wr, res_full;
    result_t res_in, res_out;

    dclp_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .tok_wr    (tok_wr),
        .tok_data  (tok_in),
        .tok_full  (tok_full)
    );

    dclp_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (2)
    ) u_tok_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_wr),
        .wr_data (tok_in),
        .full    (tok_full),
        .rd_en   (tok_rd),
        .rd_data (tok_out),
        .empty   (tok_empty)
    );

    dclp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_empty (tok_empty),
        .tok_data  (tok_out),
        .tok_rd    (tok_rd),
        .res_wr    (res_wr),
        .res_data  (res_in),
        .res_full  (res_full)
    );

    dclp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign status        = res_out.status;
    assign command       = res_out.command;
    assign param_left    = res_out.param_left;
    assign param_right   = res_out.param_right;
    assign line_checksum = res_out.line_checksum;
    assign commands_seen = res_out.commands_seen;
    assign errors_seen   = res_out.errors_seen;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the debug command line parser: random command lines and byte noise.
module tb;
    import dclp_pkg::*;

    localparam int LINE_DEPTH   = 64;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEGMENTS     = 6;
    localparam int SEGMENT_SIZE = 330;

    typedef enum logic [1:0] {
        PHASE_KEYWORD = 2'd0,
        PHASE_LEFT    = 2'd1,
        PHASE_RIGHT   = 2'd2,
        PHASE_DONE    = 2'd3
    } field_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  status;
    logic [2:0]  command;
    logic [31:0] param_left;
    logic [31:0] param_right;
    logic [7:0]  line_checksum;
    logic [31:0] commands_seen;
    logic [31:0] errors_seen;

    debug_command_line_parser #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .empty(empty),
        .pop(pop),
        .status(status),
        .command(command),
        .param_left(param_left),
        .param_right(param_right),
        .line_checksum(line_checksum),
        .commands_seen(commands_seen),
        .errors_seen(errors_seen)
    );

    string command_words [WORD_COUNT] = '{
        "START", "STOP", "RESET", "SETSPEED", "GETSTATUS", "SETPARAM", "GETPARAM"
    };
    logic [7:0] prefix_plan [SEGMENTS] = '{8'h23, 8'h00, 8'hFF, CHAR_COLON, CHAR_LF, 8'h23};

    logic [7:0]   pending_bytes [$];
    result_t      expected_lines [$];
    logic [7:0]   retired_byte;
    int           failure_count = 0;
    int           sender_idle_pct = 0;
    int           receiver_idle_pct = 0;
    bit           hold_trigger = 1'b0;
    bit           hold_done = 1'b0;
    int           long_hold_left = 0;
    int unsigned  cycle_count = 0;

    // Mirror of the parser state.
    logic [7:0]   prefix_byte = 8'h23;
    bit           in_line = 1'b0;
    int           line_bytes = 0;
    logic [6:0]   word_hits = 7'h7F;
    int           keyword_len = 0;
    field_phase_t field_phase = PHASE_KEYWORD;
    bit           saw_colon = 1'b0;
    logic [31:0]  left_acc = 32'd0;
    logic [31:0]  right_acc = 32'd0;
    logic [7:0]   line_xor = 8'h00;
    logic [31:0]  good_lines = 32'd0;
    logic [31:0]  bad_lines = 32'd0;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic void clear_line();
        line_bytes  = 0;
        word_hits   = 7'h7F;
        keyword_len = 0;
        field_phase = PHASE_KEYWORD;
        saw_colon   = 1'b0;
        left_acc    = 32'd0;
        right_acc   = 32'd0;
        line_xor    = 8'h00;
    endfunction

    function automatic void log_line_result(input status_t st, input command_t cmd,
                                            input logic [31:0] left_v,
                                            input logic [31:0] right_v);
        result_t outcome;
        if (st == STATUS_VALID) begin
            good_lines++;
        end
        else begin
            bad_lines++;
        end
        outcome.status        = st;
        outcome.command       = cmd;
        outcome.param_left    = left_v;
        outcome.param_right   = right_v;
        outcome.line_checksum = line_xor;
        outcome.commands_seen = good_lines;
        outcome.errors_seen   = bad_lines;
        expected_lines.push_back(outcome);
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b);
        int       found_idx;
        int       i;
        command_t cmd;
        if (!in_line) begin
            if (b == prefix_byte) begin
                in_line = 1'b1;
                clear_line();
            end
            return;
        end
        if (b == CHAR_LF || b == CHAR_CR) begin
            in_line = 1'b0;
            if (line_bytes == 0) begin
                clear_line();
                return;
            end
            found_idx = -1;
            for (i = 0; i < WORD_COUNT; i++) begin
                if (word_hits[i] && command_words[i].len() == keyword_len) begin
                    found_idx = i;
                end
            end
            if (found_idx < 0) begin
                log_line_result(STATUS_UNKNOWN, CMD_START, 32'd0, 32'd0);
            end
            else begin
                cmd = command_t'(found_idx);
                if (cmd != CMD_SETSPEED) begin
                    log_line_result(STATUS_VALID, cmd, 32'd0, 32'd0);
                end
                else if (saw_colon && (field_phase == PHASE_RIGHT || field_phase == PHASE_DONE))
                begin
                    log_line_result(STATUS_VALID, cmd, left_acc, right_acc);
                end
                else begin
                    log_line_result(STATUS_BAD_ARGS, cmd, 32'd0, 32'd0);
                end
            end
            clear_line();
            return;
        end
        if (line_bytes >= LINE_DEPTH - 1) begin
            in_line = 1'b0;
            log_line_result(STATUS_OVERFLOW, CMD_START, 32'd0, 32'd0);
            clear_line();
            return;
        end
        line_xor ^= b;
        // A repeated prefix in the first position enters the checksum but is not parsed.
        if (!(line_bytes == 0 && b == prefix_byte)) begin
            case (field_phase)
                PHASE_KEYWORD:
                begin
                    if (b == CHAR_COLON || b == CHAR_COMMA) begin
                        saw_colon   = (b == CHAR_COLON);
                        field_phase = PHASE_LEFT;
                    end
                    else begin
                        for (i = 0; i < WORD_COUNT; i++) begin
                            if (keyword_len >= command_words[i].len() ||
                                command_words[i][keyword_len] != b) begin
                                word_hits[i] = 1'b0;
                            end
                        end
                        if (keyword_len < KEYWORD_MAX) begin
                            keyword_len++;
                        end
                    end
                end
                PHASE_LEFT:
                begin
                    if (b == CHAR_COMMA) begin
                        field_phase = PHASE_RIGHT;
                    end
                    else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        left_acc = left_acc * 32'd10 + {24'd0, b - CHAR_ZERO};
                    end
                end
                PHASE_RIGHT:
                begin
                    if (b == CHAR_COMMA || b == CHAR_NUL) begin
                        field_phase = PHASE_DONE;
                    end
                    else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        right_acc = right_acc * 32'd10 + {24'd0, b - CHAR_ZERO};
                    end
                end
                default:
                begin
                end
            endcase
        end
        line_bytes++;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            failure_count++;
        end
    endfunction

    task automatic check_line_result();
        result_t want;
        if (expected_lines.size() == 0) begin
            $error("line result with none pending: status %0d command %0d", status, command);
            failure_count++;
            return;
        end
        want = expected_lines.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("command", 32'(want.command), 32'(command));
        check_field("param_left", want.param_left, param_left);
        check_field("param_right", want.param_right, param_right);
        check_field("line_checksum", 32'(want.line_checksum), 32'(line_checksum));
        check_field("commands_seen", want.commands_seen, commands_seen);
        check_field("errors_seen", want.errors_seen, errors_seen);
    endtask

    function automatic void queue_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_byte(s[i]);
        end
    endfunction

    function automatic void add_number();
        int roll;
        int n;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return;
        end
        if (roll < 20) begin
            add_text("4294967295");
        end
        else if (roll < 28) begin
            add_text("4294967296");
        end
        else begin
            n = $urandom_range(1, 12);
            repeat (n) queue_byte(CHAR_ZERO + 8'($urandom_range(9)));
        end
        // Stray characters inside a value are skipped by the parser.
        if ($urandom_range(99) < 10) begin
            queue_byte(8'h78);
        end
    endfunction

    function automatic void add_command_line(input logic [7:0] opener);
        int idx;
        int roll;
        int n;
        idx = $urandom_range(WORD_COUNT - 1);
        queue_byte(opener);
        if ($urandom_range(99) < 15) begin
            queue_byte(opener);
        end
        roll = $urandom_range(99);
        if (roll < 4) begin
            n = $urandom_range(16, 20);
            repeat (n) queue_byte(8'($urandom_range(8'h41, 8'h5A)));
        end
        else begin
            add_text(command_words[idx]);
            n = command_words[idx].len();
            if (roll < 10) begin
                pending_bytes[pending_bytes.size() - 1 - $urandom_range(n - 1)] =
                    8'($urandom_range(8'h41, 8'h5A));
            end
            else if (roll < 14) begin
                retired_byte = pending_bytes.pop_back();
            end
            else if (roll < 17) begin
                queue_byte(8'h53);
            end
        end
        if (idx == CMD_SETSPEED || $urandom_range(99) < 20) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
                queue_byte(CHAR_COLON);
            end
            else if (roll < 92) begin
                queue_byte(CHAR_COMMA);
            end
            if (roll < 92) begin
                add_number();
                if ($urandom_range(99) < 90) begin
                    queue_byte(CHAR_COMMA);
                    add_number();
                    roll = $urandom_range(99);
                    if (roll < 30) begin
                        queue_byte(CHAR_COMMA);
                    end
                    else if (roll < 45) begin
                        queue_byte(CHAR_NUL);
                    end
                    if (roll < 45) begin
                        add_number();
                    end
                end
            end
        end
        queue_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
    endfunction

    function automatic void add_random_line(input logic [7:0] opener);
        int roll;
        int n;
        roll = $urandom_range(99);
        if (roll < 6) begin
            n = $urandom_range(1, 6);
            repeat (n) queue_byte(8'($urandom));
        end
        else if (roll < 9) begin
            queue_byte(opener);
            queue_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
        end
        else if (roll < 13) begin
            // Lengths around the line capacity, so both the last fitting byte and overflow occur.
            queue_byte(opener);
            n = $urandom_range(LINE_DEPTH - 4, LINE_DEPTH + 4);
            repeat (n) queue_byte(8'($urandom_range(8'h20, 8'h7E)));
            queue_byte(CHAR_LF);
        end
        else begin
            add_command_line(opener);
        end
    endfunction

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_bytes.size() != 0 || push || expected_lines.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_prefix(input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk);
        while (!cfg_ready);
        prefix_byte = value;
        cfg_valid <= 1'b0;
    endtask

    // Byte driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end
        else begin
            if (push && !full) begin
                parse_rx_byte(rx_byte);
                retired_byte = pending_bytes.pop_front();
            end
            if (!(push && full)) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    push    <= 1'b1;
                    rx_byte <= pending_bytes[0];
                end
                else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end
        else begin
            if (pop && !empty) begin
                check_line_result();
            end
            if (long_hold_left != 0) begin
                long_hold_left <= long_hold_left - 1;
                pop            <= 1'b0;
            end
            else if (hold_trigger && !hold_done) begin
                long_hold_left <= HOLD_CYCLES;
                hold_done      <= 1'b1;
                pop            <= 1'b0;
            end
            else begin
                pop <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [7:0] opener;
        int         seg;
        int         budget;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (seg = 0; seg < SEGMENTS; seg++) begin
            // The first segment runs on the reset value of the prefix.
            if (seg != 0) begin
                wait_drained();
                write_prefix(prefix_plan[seg]);
            end
            @(negedge clk);
            if (seg < 2) begin
                sender_idle_pct   = 30;
                receiver_idle_pct = 84;
            end
            else if (seg < 4) begin
                sender_idle_pct   = 84;
                receiver_idle_pct = 30;
            end
            else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if (seg == 4) begin
                hold_trigger = 1'b1;
            end
            opener = prefix_plan[seg];
            if (seg == 0) begin
                add_text("x#\n##STOP\r#SETSPEED:99,7\n");
            end
            budget = pending_bytes.size() + SEGMENT_SIZE;
            while (pending_bytes.size() < budget) begin
                add_random_line(opener);
            end
        end
        wait_drained();
        if (failure_count == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
